// ===== design/rdpm_pkg.sv =====
package rdpm_pkg;

	// Defaults for the top-level parameters
	localparam int RAM_BANKS_DEF  = 5;
	localparam int BOOT_DEPTH_DEF = 32768;

	// Big address: page (3 bits) above the 16-bit CPU address
	localparam int ADDR_W = 16;
	localparam int BIG_W  = 19;
	localparam int PHYS_W = 19;
	localparam int DATA_W = 8;
	localparam int BANK_SIZE = 65536;

	typedef enum logic [1:0] {
		MODE_READ      = 2'd0,
		MODE_WRITE     = 2'd1,
		MODE_MAPPER    = 2'd2,
		MODE_BOOT_LOAD = 2'd3
	} op_t;

	// Mapper mode register bits
	localparam int MM_WIN_E000 = 7;
	localparam int MM_WIN_8000 = 6;
	localparam int MM_WIN_A000 = 5;
	localparam int MM_STACK_EN = 4;

	// Address bits 15:13 that select each window
	localparam logic [2:0] SEG_8000 = 3'd4;
	localparam logic [2:0] SEG_A000 = 3'd5;
	localparam logic [2:0] SEG_C000 = 3'd6;
	localparam logic [2:0] SEG_E000 = 3'd7;

	typedef struct packed {
		logic [BIG_W-1:0]  big;
		logic [PHYS_W-1:0] phys;
	} map_t;

endpackage

// ===== design/rdpm_mapper.sv =====
module rdpm_mapper (
	input  logic [7:0]                     mapper_mode,
	input  logic [rdpm_pkg::ADDR_W-1:0]    address,
	input  logic                           stack_request,
	output rdpm_pkg::map_t                 map
);
	import rdpm_pkg::*;

	logic [2:0] seg;
	logic [2:0] win_page;
	logic [2:0] stk_page;
	logic [2:0] page;

	assign seg      = address[ADDR_W-1:ADDR_W-3];
	assign win_page = {1'b0, mapper_mode[1:0]} + 3'd1;
	assign stk_page = {1'b0, mapper_mode[3:2]} + 3'd1;

	always_comb begin
		page = 3'd0;
		if (mapper_mode[MM_STACK_EN] && stack_request) begin
			page = stk_page;
		end else if (mapper_mode[MM_WIN_A000] && (seg == SEG_A000 || seg == SEG_C000)) begin
			page = win_page;
		end else if (mapper_mode[MM_WIN_8000] && seg == SEG_8000) begin
			page = win_page;
		end else if (mapper_mode[MM_WIN_E000] && seg == SEG_E000) begin
			page = win_page;
		end
	end

	// Page lands above the 16-bit address, so the add is a concatenation
	assign map.big  = {page, address};
	// Bank interleave: keep 18:15, move 12:0 up by two, bring 14:13 down
	assign map.phys = {map.big[18:15], map.big[12:0], map.big[14:13]};

endmodule

// ===== design/rdpm_ram.sv =====
module rdpm_ram #(
	parameter int RAM_BANKS = rdpm_pkg::RAM_BANKS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req,
	input  logic                           we,
	input  logic [rdpm_pkg::PHYS_W-1:0]    addr,
	input  logic [rdpm_pkg::DATA_W-1:0]    wdata,
	output logic [rdpm_pkg::DATA_W-1:0]    rdata,
	output logic                           clearing
);
	import rdpm_pkg::*;

	localparam int RAM_DEPTH = RAM_BANKS * BANK_SIZE;

	logic [DATA_W-1:0] mem [RAM_DEPTH];
	logic [PHYS_W-1:0] clr_q;
	logic              clearing_q;

	assign clearing = clearing_q;

	// Sweep every entry to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_q <= clr_q + PHYS_W'(1);
			if (clr_q == PHYS_W'(RAM_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_q] <= '0;
		end else if (req && we) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req && !we) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== design/rdpm_boot_rom.sv =====
module rdpm_boot_rom #(
	parameter int BOOT_DEPTH = rdpm_pkg::BOOT_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [rdpm_pkg::ADDR_W-1:0]    waddr,
	input  logic [rdpm_pkg::DATA_W-1:0]    wdata,
	input  logic                           re,
	input  logic [rdpm_pkg::BIG_W-1:0]     raddr,
	output logic [rdpm_pkg::DATA_W-1:0]    rdata
);
	import rdpm_pkg::*;

	localparam int BOOT_AW = (BOOT_DEPTH > 1) ? $clog2(BOOT_DEPTH) : 1;

	logic [DATA_W-1:0] rom [BOOT_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			rom[waddr[BOOT_AW-1:0]] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= rom[raddr[BOOT_AW-1:0]];
		end
	end

endmodule

// ===== design/ram_disk_page_mapper.sv =====
// Channel   Ports                                     Direction  Handshake
// request   mode, address, data, stack_request        in         start & !busy
// result    read_data, from_boot                      out        done, one cycle
// config    cfg_we, cfg_wdata (boot_length)           in         cfg_we
//
// One request per cycle while busy is low: the RAM and boot ROM are read or
// written at the accepting edge and the result shows with done in the next cycle.
// After reset busy stays high while the RAM is swept to zero; config writes
// are taken during the sweep.
// The receiver cannot stall, so busy is high only during that sweep.
module ram_disk_page_mapper #(
	parameter int RAM_BANKS  = rdpm_pkg::RAM_BANKS_DEF,
	parameter int BOOT_DEPTH = rdpm_pkg::BOOT_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     mode,
	input  logic [rdpm_pkg::ADDR_W-1:0]    address,
	input  logic [rdpm_pkg::DATA_W-1:0]    data,
	input  logic                           stack_request,
	output logic                           done,
	output logic [rdpm_pkg::DATA_W-1:0]    read_data,
	output logic                           from_boot,
	input  logic                           cfg_we,
	input  logic [15:0]                    cfg_wdata
);
	import rdpm_pkg::*;

	localparam int RAM_DEPTH = RAM_BANKS * BANK_SIZE;
	localparam logic [16:0] BOOT_LIM = 17'(BOOT_DEPTH);

	op_t               op;
	logic              accept;
	logic              clearing;
	logic [7:0]        mapper_mode_q;
	logic [15:0]       boot_length_q;
	map_t              map;
	logic [16:0]       limit;
	logic              boot_hit;
	logic              in_range;
	logic              ram_req;
	logic              boot_we;
	logic [DATA_W-1:0] ram_rdata;
	logic [DATA_W-1:0] boot_rdata;
	logic              done_s1;
	logic              rd_s1;
	logic              hit_s1;
	logic              inr_s1;

	assign op     = op_t'(mode);
	assign busy   = clearing;
	assign accept = start && !clearing;

	rdpm_mapper u_mapper (
		.mapper_mode   (mapper_mode_q),
		.address       (address),
		.stack_request (stack_request),
		.map           (map)
	);

	// Overlay covers big addresses below both boot_length and the ROM depth
	assign limit    = ({1'b0, boot_length_q} < BOOT_LIM) ? {1'b0, boot_length_q} : BOOT_LIM;
	assign boot_hit = (limit != '0) && (map.big < {2'b00, limit});
	assign in_range = {1'b0, map.phys} < 20'(RAM_DEPTH);
	assign ram_req  = accept && (op == MODE_READ || op == MODE_WRITE) && in_range;
	assign boot_we  = accept && (op == MODE_BOOT_LOAD) && ({1'b0, address} < BOOT_LIM);

	rdpm_ram #(
		.RAM_BANKS (RAM_BANKS)
	) u_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (ram_req),
		.we       (op == MODE_WRITE),
		.addr     (map.phys),
		.wdata    (data),
		.rdata    (ram_rdata),
		.clearing (clearing)
	);

	rdpm_boot_rom #(
		.BOOT_DEPTH (BOOT_DEPTH)
	) u_boot_rom (
		.clk   (clk),
		.we    (boot_we),
		.waddr (address),
		.wdata (data),
		.re    (accept && op == MODE_READ && boot_hit),
		.raddr (map.big),
		.rdata (boot_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mapper_mode_q <= '0;
			boot_length_q <= '0;
			done_s1       <= 1'b0;
		end else begin
			done_s1 <= accept;
			if (accept && op == MODE_MAPPER) begin
				mapper_mode_q <= data;
			end
			if (cfg_we) begin
				boot_length_q <= cfg_wdata;
			end
		end
	end

	// Hold the read steering until the memories return data
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1  <= (op == MODE_READ);
			hit_s1 <= boot_hit;
			inr_s1 <= in_range;
		end
	end

	always_comb begin
		read_data = '0;
		from_boot = 1'b0;
		if (rd_s1) begin
			if (hit_s1) begin
				read_data = boot_rdata;
				from_boot = 1'b1;
			end else if (inr_s1) begin
				read_data = ram_rdata;
			end
		end
	end

	assign done = done_s1;

endmodule

// ===== tb/tb_ram_disk_page_mapper.sv =====
module tb_ram_disk_page_mapper;
	import rdpm_pkg::*;

	localparam int          CLK_PERIOD    = 20;
	localparam int          TIMEOUT       = CLK_PERIOD * 1_500_000;
	localparam int          DRAIN_CYCLES  = 4;
	localparam int          IDLE_PERCENT  = 32;
	localparam int unsigned RAM_DEPTH     = RAM_BANKS_DEF * BANK_SIZE;
	localparam int unsigned BANK_HI_MASK  = 32'h78000;
	localparam int unsigned BANK_MID_MASK = 32'h7ffc;
	localparam int unsigned LANE_MASK     = 32'h3;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              from_boot;
	} bus_result_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [1:0]        mode;
	logic [ADDR_W-1:0] address;
	logic [DATA_W-1:0] data;
	logic              stack_request;
	logic              done;
	logic [DATA_W-1:0] read_data;
	logic              from_boot;
	logic              cfg_we;
	logic [15:0]       cfg_wdata;

	// Shadow state of the mapper
	logic [7:0]        map_reg;
	logic [15:0]       boot_len;
	logic [7:0]        ram_img [int];
	logic [7:0]        boot_img [int];

	bus_result_t       bus_result_q [$];
	logic [16:0]       touched_q [$];
	bit                steady;
	int                mismatches;
	int                checked;
	int                n_reads;
	int                n_boot_hits;
	int                n_writes;
	int                n_maps;
	int                n_loads;

	ram_disk_page_mapper #(
		.RAM_BANKS  (RAM_BANKS_DEF),
		.BOOT_DEPTH (BOOT_DEPTH_DEF)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.mode          (mode),
		.address       (address),
		.data          (data),
		.stack_request (stack_request),
		.done          (done),
		.read_data     (read_data),
		.from_boot     (from_boot),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int unsigned to_big(logic [15:0] addr, logic stk);
		int unsigned win_page;
		int unsigned stk_page;
		win_page = (int'(map_reg[1:0]) + 1) << 16;
		stk_page = (int'(map_reg[3:2]) + 1) << 16;
		if (map_reg[MM_STACK_EN] && stk)
			return addr + stk_page;
		if (map_reg[MM_WIN_A000] && (addr[15:13] == SEG_A000 || addr[15:13] == SEG_C000))
			return addr + win_page;
		if (map_reg[MM_WIN_8000] && addr[15:13] == SEG_8000)
			return addr + win_page;
		if (map_reg[MM_WIN_E000] && addr[15:13] == SEG_E000)
			return addr + win_page;
		return addr;
	endfunction

	function automatic int unsigned to_phys(int unsigned big);
		return (big & BANK_HI_MASK) | ((big << 2) & BANK_MID_MASK) | ((big >> 13) & LANE_MASK);
	endfunction

	function automatic int unsigned boot_limit();
		return (boot_len < BOOT_DEPTH_DEF) ? boot_len : BOOT_DEPTH_DEF;
	endfunction

	function automatic bus_result_t predict_access(op_t op, logic [15:0] addr, logic [7:0] din,
			logic stk);
		bus_result_t res;
		int unsigned big;
		int unsigned phys;
		res = '0;
		case (op)
			MODE_READ: begin
				n_reads++;
				big = to_big(addr, stk);
				if (big < boot_limit()) begin
					res.read_data = boot_img[big];
					res.from_boot = 1'b1;
					n_boot_hits++;
				end else begin
					phys = to_phys(big);
					if (phys < RAM_DEPTH && ram_img.exists(phys))
						res.read_data = ram_img[phys];
				end
			end
			MODE_WRITE: begin
				n_writes++;
				phys = to_phys(to_big(addr, stk));
				if (phys < RAM_DEPTH)
					ram_img[phys] = din;
			end
			MODE_MAPPER: begin
				n_maps++;
				map_reg = din;
			end
			default: begin
				n_loads++;
				if (addr < BOOT_DEPTH_DEF)
					boot_img[addr] = din;
			end
		endcase
		return res;
	endfunction

	task automatic send_request(op_t op, logic [15:0] addr, logic [7:0] din, logic stk);
		bit taken;
		start         <= 1'b1;
		mode          <= op;
		address       <= addr;
		data          <= din;
		stack_request <= stk;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		bus_result_q = {bus_result_q, predict_access(op, addr, din, stk)};
		while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Load the boot entry first where the read would land on an unloaded one
	task automatic send_read(logic [15:0] addr, logic stk);
		int unsigned big;
		big = to_big(addr, stk);
		if (big < boot_limit() && !boot_img.exists(big))
			send_request(MODE_BOOT_LOAD, big[15:0], 8'($urandom), 1'($urandom_range(1)));
		send_request(MODE_READ, addr, 8'($urandom), stk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (bus_result_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_boot_length(logic [15:0] len);
		cfg_we    <= 1'b1;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_we    <= 1'b0;
		boot_len  = len;
	endtask

	task automatic test_clear_and_windows();
		send_read(16'h0000, 1'b0);
		send_read(16'hffff, 1'b1);
		send_request(MODE_WRITE, 16'h0000, 8'hff, 1'b0);
		send_request(MODE_WRITE, 16'hffff, 8'h00, 1'b1);
		send_request(MODE_WRITE, 16'ha000, 8'h5a, 1'b0);
		// all three windows on, map page 2
		send_request(MODE_MAPPER, 16'h0000, 8'he1, 1'b0);
		send_request(MODE_WRITE, 16'ha000, 8'ha5, 1'b0);
		send_read(16'ha000, 1'b0);
		send_read(16'hdfff, 1'b0);
		send_request(MODE_WRITE, 16'h9fff, 8'h81, 1'b0);
		send_read(16'h9fff, 1'b0);
		send_read(16'he000, 1'b0);
		// stack page 4 only
		send_request(MODE_MAPPER, 16'h0000, 8'h1c, 1'b0);
		send_request(MODE_WRITE, 16'hffff, 8'h3c, 1'b1);
		send_read(16'hffff, 1'b1);
		send_read(16'hffff, 1'b0);
		send_request(MODE_MAPPER, 16'h0000, 8'h00, 1'b0);
		send_read(16'ha000, 1'b0);
		drain();
	endtask

	task automatic test_boot_overlay();
		send_request(MODE_BOOT_LOAD, 16'h0000, 8'h11, 1'b0);
		send_request(MODE_BOOT_LOAD, 16'h0001, 8'hee, 1'b0);
		send_request(MODE_BOOT_LOAD, 16'h7fff, 8'h80, 1'b1);
		// past the ROM depth: dropped
		send_request(MODE_BOOT_LOAD, 16'h8000, 8'h01, 1'b0);
		send_request(MODE_BOOT_LOAD, 16'hffff, 8'h7f, 1'b0);
		drain();
		write_boot_length(16'h0002);
		send_read(16'h0000, 1'b0);
		send_read(16'h0001, 1'b0);
		send_read(16'h0002, 1'b0);
		// write under the overlay lands in RAM, read still comes from ROM
		send_request(MODE_WRITE, 16'h0000, 8'h42, 1'b0);
		send_read(16'h0000, 1'b0);
		drain();
		// length beyond the ROM depth clips at the depth
		write_boot_length(16'hffff);
		send_read(16'h7fff, 1'b0);
		send_read(16'h8000, 1'b0);
		drain();
	endtask

	task automatic test_random_traffic(int unsigned count, bit calm);
		int unsigned pick;
		logic [16:0] slot;
		steady = calm;
		repeat (count) begin
			pick = $urandom_range(99);
			if (touched_q.size() != 0 && $urandom_range(1) == 1)
				slot = touched_q[$urandom_range(touched_q.size() - 1)];
			else
				slot = {($urandom_range(2) == 0), 16'($urandom)};
			if (pick < 8) begin
				send_request(MODE_MAPPER, slot[15:0], 8'($urandom), slot[16]);
			end else if (pick < 14) begin
				// keep most loads inside the ROM
				if ($urandom_range(3) != 0)
					send_request(MODE_BOOT_LOAD, {1'b0, slot[14:0]}, 8'($urandom), slot[16]);
				else
					send_request(MODE_BOOT_LOAD, slot[15:0], 8'($urandom), slot[16]);
			end else if (pick < 50) begin
				send_request(MODE_WRITE, slot[15:0], 8'($urandom), slot[16]);
				touched_q = {touched_q, slot};
				if (touched_q.size() > 64)
					void'(touched_q.pop_front());
			end else begin
				send_read(slot[15:0], slot[16]);
			end
		end
		drain();
		steady = 1'b0;
	endtask

	always @(negedge clk) begin
		bus_result_t exp_res;
		if (arst_n && done) begin
			if (bus_result_q.size() == 0) begin
				$error("unexpected result: read_data=%0h from_boot=%0b", read_data, from_boot);
				mismatches++;
			end else begin
				exp_res = bus_result_q.pop_front();
				checked++;
				if (read_data !== exp_res.read_data) begin
					$error("read_data: expected %0h, got %0h", exp_res.read_data, read_data);
					mismatches++;
				end
				if (from_boot !== exp_res.from_boot) begin
					$error("from_boot: expected %0b, got %0b", exp_res.from_boot, from_boot);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#(TIMEOUT);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		start         = 1'b0;
		mode          = MODE_READ;
		address       = '0;
		data          = '0;
		stack_request = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		map_reg       = '0;
		boot_len      = '0;
		steady        = 1'b0;
		mismatches    = 0;
		checked       = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		write_boot_length(16'h0000);

		test_clear_and_windows();
		test_boot_overlay();

		write_boot_length(16'h8000);
		test_random_traffic(150, 1'b0);
		write_boot_length(16'h0000);
		test_random_traffic(150, 1'b1);
		write_boot_length(16'hffff);
		test_random_traffic(150, 1'b0);
		write_boot_length(16'($urandom_range(32767, 1)));
		test_random_traffic(150, 1'b0);
		write_boot_length(16'h0001);
		test_random_traffic(150, 1'b0);
		write_boot_length(16'($urandom));
		test_random_traffic(150, 1'b0);

		if (bus_result_q.size() != 0) begin
			$error("%0d results never arrived", bus_result_q.size());
			mismatches++;
		end
		$display("Covered %0d reads (%0d served by boot ROM), %0d writes, %0d mapper updates,",
			n_reads, n_boot_hits, n_writes, n_maps);
		$display("%0d boot loads; %0d results checked, %0d mismatches", n_loads, checked,
			mismatches);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/rdpm_pkg.sv
design/rdpm_mapper.sv
design/rdpm_ram.sv
design/rdpm_boot_rom.sv
design/ram_disk_page_mapper.sv
tb/tb_ram_disk_page_mapper.sv
